// ----- rtl/neighborhood_drop_rise_mask_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the drop/rise mask block
// Concurrent checks on the block clock, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef NEIGHBORHOOD_DROP_RISE_MASK_MACROS_SVH
`define NEIGHBORHOOD_DROP_RISE_MASK_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define NDRM_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define NDRM_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/ndrm_pkg.sv -----
// ----------------------------------------------------------------------------
// ndrm_pkg
// Shared constants and types of the neighbourhood drop/rise mask block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ndrm_pkg;

    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_HEIGHT_BITS = 20;

    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 20;
    localparam int GW_BITS       = 11;
    localparam int GH_BITS       = 16;
    localparam int THR_BITS      = 20;
    localparam int COL_OUT_BITS  = 10;
    localparam int ROW_BITS      = 16;
    localparam int RESULTS_MAX   = 4;
    localparam int OUT_DATA_BITS = 32;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_GRID_WIDTH     = 4'd0,
        REG_GRID_HEIGHT    = 4'd1,
        REG_DROP_THRESHOLD = 4'd2,
        REG_RISE_THRESHOLD = 4'd3
    } cfg_reg_t;

    // One result item, last field in the lowest bits.
    typedef struct packed {
        logic                    rise_flag;
        logic                    drop_flag;
        logic [ROW_BITS-1:0]     cell_row;
        logic [COL_OUT_BITS-1:0] cell_column;
    } result_t;

    localparam int RESULT_BITS = $bits(result_t);

endpackage

// ----- rtl/neighborhood_drop_rise_mask.sv -----
// ----------------------------------------------------------------------------
// neighborhood_drop_rise_mask
// 3x3 morphological drop/rise flags over a raster stream of signed heights.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Contents
//  s_*       in         s_tvalid / s_tready   one height sample per item
//  m_*       out        m_tvalid / m_tready   one cell result per item
//  cfg_*     in         cfg_valid / cfg_ready register index and write data
//
//  One sample is accepted per cycle unless the result buffer holds more than its
//  last result, or that one is stalled. Results are registered in a four-entry
//  buffer that drains one result per cycle while m_tready is high, so a sample
//  that releases n results (n up to four, at row ends and on the last row)
//  occupies the output until all n have left. Line buffer reads are registered;
//  a same-address write at the edge of the read is forwarded. Reset is
//  synchronous and needs no clearing pass. A stalled output holds the result
//  buffer and the working item, and with them the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "neighborhood_drop_rise_mask_macros.svh"

module neighborhood_drop_rise_mask
    import ndrm_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS,
    localparam int IN_BITS    = ((HEIGHT_BITS + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Input samples.
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_BITS-1:0]       s_tdata,   // [HEIGHT_BITS-1:0] sample_height
    // Results.
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,   // [9:0] cell_column, [25:10] cell_row,
                                                // [26] drop_flag, [27] rise_flag
    output logic                     m_tlast,   // last_of_run
    // Configuration writes.
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DW = (HEIGHT_BITS + 1 > THR_BITS + 1) ? HEIGHT_BITS + 1 : THR_BITS + 1;

    typedef logic signed [HEIGHT_BITS-1:0] height_t;

    function automatic height_t min2(input height_t a, input height_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic height_t max2(input height_t a, input height_t b);
        return (a > b) ? a : b;
    endfunction

    // Configuration registers.
    logic [GW_BITS-1:0]  grid_width_reg;
    logic [GH_BITS-1:0]  grid_height_reg;
    logic [THR_BITS-1:0] drop_thr_reg;
    logic [THR_BITS-1:0] rise_thr_reg;

    // Raster position of the next accepted item.
    logic [CW-1:0]       col_count_reg;
    logic [ROW_BITS-1:0] row_count_reg;
    logic [CW-1:0]       w_last;
    logic [ROW_BITS-1:0] h_last;

    // Line buffers.
    height_t upper_mem_reg  [MAX_WIDTH];
    height_t middle_mem_reg [MAX_WIDTH];
    height_t upper_q_reg;
    height_t middle_q_reg;

    // Working stage.
    logic                s1_valid_reg;
    height_t             s1_height_reg;
    logic [CW-1:0]       s1_col_reg;
    logic [ROW_BITS-1:0] s1_row_reg;
    logic                s1_row_end_reg;
    logic                s1_last_row_reg;
    logic                byp_reg;
    height_t             byp_mid_reg;
    height_t             byp_up_reg;

    height_t win_left_reg [3];
    height_t win_prev_reg [3];

    // Result buffer.
    result_t    res_reg [RESULTS_MAX];
    logic [2:0] res_cnt_reg;

    logic s_fire, s1_fire, m_fire, cfg_fire;
    logic geometry_write;

    height_t mid_raw, up_raw;
    height_t cur [3];
    height_t left_e [3];
    height_t prev_e [3];
    height_t fmin_l, fmin_p, fmin_c, fmax_l, fmax_p, fmax_c;
    height_t pmin_l, pmin_p, pmin_c, pmax_l, pmax_p, pmax_c;
    height_t e_min [RESULTS_MAX];
    height_t e_max [RESULTS_MAX];
    height_t e_ctr [RESULTS_MAX];
    logic    e_vld [RESULTS_MAX];
    logic [COL_OUT_BITS-1:0] e_col [RESULTS_MAX];
    logic [ROW_BITS-1:0]     e_row [RESULTS_MAX];
    result_t res_next [RESULTS_MAX];
    logic [2:0] res_cnt_next;

    logic col_first, r_ge1, r_ge2;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign geometry_write = cfg_fire && ((cfg_reg_t'(cfg_addr) == REG_GRID_WIDTH) ||
                                         (cfg_reg_t'(cfg_addr) == REG_GRID_HEIGHT));

    assign m_tvalid = (res_cnt_reg != 3'd0);
    assign m_tlast  = (res_cnt_reg == 3'd1);
    assign m_tdata  = OUT_DATA_BITS'(res_reg[0]);
    assign m_fire   = m_tvalid && m_tready;

    assign s1_fire  = s1_valid_reg &&
                      ((res_cnt_reg == 3'd0) || ((res_cnt_reg == 3'd1) && m_tready));
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_fire   = s_tvalid && s_tready;

    // Effective geometry: width clamps to 1..MAX_WIDTH, height 0 acts as 1.
    always_comb begin
        if (grid_width_reg == '0) begin
            w_last = '0;
        end else if (32'(grid_width_reg) > MAX_WIDTH) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(grid_width_reg - GW_BITS'(1));
        end
        h_last = (grid_height_reg == '0) ? '0 : grid_height_reg - ROW_BITS'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= GW_BITS'(1);
            grid_height_reg <= GH_BITS'(1);
            drop_thr_reg    <= '0;
            rise_thr_reg    <= '0;
        end else if (cfg_fire) begin
            case (cfg_reg_t'(cfg_addr))
                REG_GRID_WIDTH:     grid_width_reg  <= cfg_data[GW_BITS-1:0];
                REG_GRID_HEIGHT:    grid_height_reg <= cfg_data[GH_BITS-1:0];
                REG_DROP_THRESHOLD: drop_thr_reg    <= cfg_data[THR_BITS-1:0];
                REG_RISE_THRESHOLD: rise_thr_reg    <= cfg_data[THR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Position counters; a geometry write restarts the grid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (geometry_write) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (s_fire) begin
            if (col_count_reg == w_last) begin
                col_count_reg <= '0;
                row_count_reg <= (row_count_reg == h_last) ? '0 : row_count_reg + ROW_BITS'(1);
            end else begin
                col_count_reg <= col_count_reg + CW'(1);
            end
        end
    end

    // Line buffer reads at the column of the item being accepted.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            upper_q_reg  <= upper_mem_reg[col_count_reg];
            middle_q_reg <= middle_mem_reg[col_count_reg];
        end
    end

    // Line buffer writes as the working item completes.
    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            upper_mem_reg[s1_col_reg]  <= mid_raw;
            middle_mem_reg[s1_col_reg] <= s1_height_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end else begin
            if (s_fire) begin
                s1_valid_reg <= 1'b1;
                // The read above misses a write to the same entry at this edge.
                byp_reg      <= s1_fire && (s1_col_reg == col_count_reg);
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_height_reg   <= s_tdata[HEIGHT_BITS-1:0];
            s1_col_reg      <= col_count_reg;
            s1_row_reg      <= row_count_reg;
            s1_row_end_reg  <= (col_count_reg == w_last);
            s1_last_row_reg <= (row_count_reg == h_last);
            byp_mid_reg     <= s1_height_reg;
            byp_up_reg      <= mid_raw;
        end
    end

    assign mid_raw   = byp_reg ? byp_mid_reg : middle_q_reg;
    assign up_raw    = byp_reg ? byp_up_reg  : upper_q_reg;
    assign col_first = (s1_col_reg == '0);
    assign r_ge1     = (s1_row_reg != '0);
    assign r_ge2     = (s1_row_reg > ROW_BITS'(1));

    // Neighbourhood columns, with the top and left edges replicated.
    always_comb begin
        cur[2] = s1_height_reg;
        cur[1] = r_ge1 ? mid_raw : cur[2];
        cur[0] = r_ge2 ? up_raw  : cur[1];
        for (int i = 0; i < 3; i++) begin
            left_e[i] = col_first ? cur[i] : win_left_reg[i];
            prev_e[i] = col_first ? cur[i] : win_prev_reg[i];
        end
    end

    // Column minimum and maximum over all three rows and over the lower two,
    // the latter serving the bottom edge.
    always_comb begin
        pmin_l = min2(left_e[1], left_e[2]);
        pmin_p = min2(prev_e[1], prev_e[2]);
        pmin_c = min2(cur[1], cur[2]);
        pmax_l = max2(left_e[1], left_e[2]);
        pmax_p = max2(prev_e[1], prev_e[2]);
        pmax_c = max2(cur[1], cur[2]);
        fmin_l = min2(left_e[0], pmin_l);
        fmin_p = min2(prev_e[0], pmin_p);
        fmin_c = min2(cur[0], pmin_c);
        fmax_l = max2(left_e[0], pmax_l);
        fmax_p = max2(prev_e[0], pmax_p);
        fmax_c = max2(cur[0], pmax_c);
    end

    // Candidate results in release order: the cell behind in the row above,
    // the right edge of the row above, then the same two on the last row.
    always_comb begin
        e_vld[0] = r_ge1 && !col_first;
        e_vld[1] = r_ge1 && s1_row_end_reg;
        e_vld[2] = s1_last_row_reg && !col_first;
        e_vld[3] = s1_last_row_reg && s1_row_end_reg;

        e_min[0] = min2(fmin_l, min2(fmin_p, fmin_c));
        e_max[0] = max2(fmax_l, max2(fmax_p, fmax_c));
        e_min[1] = min2(fmin_p, fmin_c);
        e_max[1] = max2(fmax_p, fmax_c);
        e_min[2] = min2(pmin_l, min2(pmin_p, pmin_c));
        e_max[2] = max2(pmax_l, max2(pmax_p, pmax_c));
        e_min[3] = min2(pmin_p, pmin_c);
        e_max[3] = max2(pmax_p, pmax_c);

        e_ctr[0] = prev_e[1];
        e_ctr[1] = cur[1];
        e_ctr[2] = prev_e[2];
        e_ctr[3] = cur[2];

        e_col[0] = COL_OUT_BITS'(s1_col_reg - CW'(1));
        e_col[1] = COL_OUT_BITS'(s1_col_reg);
        e_col[2] = e_col[0];
        e_col[3] = e_col[1];

        e_row[0] = s1_row_reg - ROW_BITS'(1);
        e_row[1] = e_row[0];
        e_row[2] = s1_row_reg;
        e_row[3] = s1_row_reg;
    end

    // Flag evaluation and packing of the valid results to the buffer front.
    always_comb begin
        logic signed [DW-1:0] d_drop;
        logic signed [DW-1:0] d_rise;
        result_t r;
        for (int i = 0; i < RESULTS_MAX; i++) begin
            res_next[i] = '0;
        end
        res_cnt_next = 3'd0;
        for (int i = 0; i < RESULTS_MAX; i++) begin
            d_drop = DW'(e_ctr[i]) - DW'(e_min[i]);
            d_rise = DW'(e_max[i]) - DW'(e_ctr[i]);
            r.cell_column = e_col[i];
            r.cell_row    = e_row[i];
            r.drop_flag   = (d_drop >= $signed(DW'(drop_thr_reg)));
            r.rise_flag   = (d_rise >= $signed(DW'(rise_thr_reg)));
            if (e_vld[i]) begin
                res_next[res_cnt_next[1:0]] = r;
                res_cnt_next = res_cnt_next + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                win_left_reg[i] <= '0;
                win_prev_reg[i] <= '0;
            end
        end else if (s1_fire) begin
            for (int i = 0; i < 3; i++) begin
                win_left_reg[i] <= prev_e[i];
                win_prev_reg[i] <= cur[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_cnt_reg <= 3'd0;
        end else if (s1_fire) begin
            res_cnt_reg <= res_cnt_next;
        end else if (m_fire) begin
            res_cnt_reg <= res_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            for (int i = 0; i < RESULTS_MAX; i++) begin
                res_reg[i] <= res_next[i];
            end
        end else if (m_fire) begin
            for (int i = 0; i < RESULTS_MAX - 1; i++) begin
                res_reg[i] <= res_reg[i + 1];
            end
        end
    end

    `NDRM_ASSERT(a_res_cnt_bound, res_cnt_reg <= 3'd4, "result buffer count out of range")
    `NDRM_ASSERT(a_col_in_row, col_count_reg <= w_last, "column counter beyond row width")
    `NDRM_ASSERT(a_row_in_grid, row_count_reg <= h_last, "row counter beyond grid height")
    `NDRM_ASSERT_NEXT(a_run_continues, m_fire && (res_cnt_reg > 3'd1), m_tvalid, "run broken off")

endmodule

// ----- tb/neighborhood_drop_rise_mask_test.sv -----
// ----------------------------------------------------------------------------
// neighborhood_drop_rise_mask_test
// Self-checking bench for the 3x3 drop/rise mask. A local model of the line
// buffers and the window predicts every cell result, and each result item
// is compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module neighborhood_drop_rise_mask_test;
    import ndrm_pkg::*;

    localparam int HEIGHT_W    = DEF_HEIGHT_BITS;
    localparam int IN_BITS     = ((DEF_HEIGHT_BITS + 7) / 8) * 8;
    localparam int MAX_CELLS   = DEF_MAX_WIDTH;
    localparam int CYCLE_LIMIT = 250000;
    localparam int SETTLE      = 8;
    localparam int RANDOM_SAMPLES = 144;
    localparam int WIDE_SAMPLES   = 40;
    localparam int PHASE_CELLS    = 48;
    localparam int REPORT_MAX  = 10;

    localparam logic [THR_BITS-1:0]      THR_MAX    = '1;
    localparam logic [HEIGHT_W-1:0]      HEIGHT_MIN = {1'b1, {(HEIGHT_W-1){1'b0}}};
    localparam logic [HEIGHT_W-1:0]      HEIGHT_MAX = {1'b0, {(HEIGHT_W-1){1'b1}}};
    localparam logic [CFG_ADDR_BITS-1:0] REG_UNMAPPED   = 4'd9;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ADDR_LAST  = '1;

    // Three heights of one window column: [0] upper row, [1] middle, [2] lower.
    typedef logic [2:0][31:0] stack_t;

    typedef struct packed {
        logic [COL_OUT_BITS-1:0] column;
        logic [ROW_BITS-1:0]     row;
        logic                    drop;
        logic                    rise;
        logic                    last;
    } cell_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_BITS-1:0]       s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     m_tlast;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    neighborhood_drop_rise_mask dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Local copy of the block's registers and storage.
    logic [GW_BITS-1:0]  grid_width_reg  = 11'd1;
    logic [GH_BITS-1:0]  grid_height_reg = 16'd1;
    logic [THR_BITS-1:0] drop_thr = '0;
    logic [THR_BITS-1:0] rise_thr = '0;
    int     upper_line [MAX_CELLS];
    int     middle_line [MAX_CELLS];
    stack_t win_left = '0;
    stack_t win_prev = '0;
    int     col_cnt = 0;
    int     row_cnt = 0;

    cell_result_t expected_cells [$];

    bit steady = 1'b0;
    int terrain_base = 0;
    int samples_sent = 0;
    int results_checked = 0;
    int cfg_writes = 0;
    int error_count = 0;
    int report_count = 0;
    int cycle_count = 0;

    function automatic cell_result_t grade_cell(input int col, input int row,
                                                input stack_t a, input stack_t b,
                                                input stack_t c);
        stack_t       cols [3];
        cell_result_t res;
        int           centre, lo, hi, v;
        cols[0] = a;
        cols[1] = b;
        cols[2] = c;
        centre = b[1];
        lo = centre;
        hi = centre;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                v = cols[i][k];
                if (v < lo) lo = v;
                if (v > hi) hi = v;
            end
        end
        res.column = col[COL_OUT_BITS-1:0];
        res.row    = row[ROW_BITS-1:0];
        res.drop   = (centre - lo) >= int'(drop_thr);
        res.rise   = (hi - centre) >= int'(rise_thr);
        res.last   = 1'b0;
        return res;
    endfunction

    function automatic void predict_flags(input logic [HEIGHT_W-1:0] raw);
        int           w, h, c, r, n, sample;
        bit           row_end, last_row;
        stack_t       cur, left, prev, lr, pr, cr;
        cell_result_t found [RESULTS_MAX];
        w = (grid_width_reg == 0) ? 1 :
            (grid_width_reg > MAX_CELLS) ? MAX_CELLS : int'(grid_width_reg);
        h = (grid_height_reg == 0) ? 1 : int'(grid_height_reg);
        c = col_cnt % w;
        r = row_cnt % h;
        row_end  = (c == w - 1);
        last_row = (r == h - 1);
        sample = $signed(raw);
        cur[2] = sample;
        cur[1] = (r >= 1) ? middle_line[c] : cur[2];
        cur[0] = (r >= 2) ? upper_line[c] : cur[1];
        if (c == 0) begin
            win_left = cur;
            win_prev = cur;
        end
        left = win_left;
        prev = win_prev;
        n = 0;
        // The row above is finished while this row streams in.
        if (r >= 1) begin
            if (c >= 1) begin
                found[n] = grade_cell(c - 1, r - 1, left, prev, cur);
                n++;
            end
            if (row_end) begin
                found[n] = grade_cell(w - 1, r - 1, prev, cur, cur);
                n++;
            end
        end
        // On the last row the lower edge is replicated from the row itself.
        if (last_row) begin
            lr[0] = left[1]; lr[1] = left[2]; lr[2] = left[2];
            pr[0] = prev[1]; pr[1] = prev[2]; pr[2] = prev[2];
            cr[0] = cur[1];  cr[1] = cur[2];  cr[2] = cur[2];
            if (c >= 1) begin
                found[n] = grade_cell(c - 1, r, lr, pr, cr);
                n++;
            end
            if (row_end) begin
                found[n] = grade_cell(w - 1, r, pr, cr, cr);
                n++;
            end
        end
        if (n > 0) found[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) expected_cells.insert(expected_cells.size(), found[i]);
        win_left = prev;
        win_prev = cur;
        upper_line[c]  = middle_line[c];
        middle_line[c] = cur[2];
        if (row_end) begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
            row_cnt = r;
        end
    endfunction

    function automatic void apply_register(input logic [CFG_ADDR_BITS-1:0] addr,
                                           input logic [CFG_DATA_BITS-1:0] value);
        case (addr)
            REG_GRID_WIDTH: begin
                grid_width_reg = value[GW_BITS-1:0];
                col_cnt = 0;
                row_cnt = 0;
            end
            REG_GRID_HEIGHT: begin
                grid_height_reg = value[GH_BITS-1:0];
                col_cnt = 0;
                row_cnt = 0;
            end
            REG_DROP_THRESHOLD: drop_thr = value[THR_BITS-1:0];
            REG_RISE_THRESHOLD: rise_thr = value[THR_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [HEIGHT_W-1:0] pick_height();
        int v;
        if ($urandom_range(3) == 0) return HEIGHT_W'($urandom);
        // Mostly gentle terrain so that both flags change from cell to cell.
        v = terrain_base + int'($urandom_range(128)) - 64;
        return v[HEIGHT_W-1:0];
    endfunction

    function automatic logic [THR_BITS-1:0] pick_threshold();
        case ($urandom_range(5))
            0:       return '0;
            1:       return THR_MAX;
            2, 3:    return THR_BITS'($urandom_range(96));
            default: return THR_BITS'($urandom);
        endcase
    endfunction

    task automatic send_height(input logic [HEIGHT_W-1:0] h);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_BITS'(h);
        do @(posedge aclk); while (!s_tready);
        predict_flags(h);
        samples_sent++;
    endtask

    task automatic write_register(input logic [CFG_ADDR_BITS-1:0] addr,
                                  input logic [CFG_DATA_BITS-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        apply_register(addr, value);
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stops the input and waits until every predicted result has left the
    // block, then waits on a little longer for samples that released nothing.
    task automatic settle_block();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic test_reset_defaults();
        // One-cell grid straight after reset: each item is its own grid.
        send_height(HEIGHT_MIN);
        send_height(HEIGHT_MAX);
        send_height('0);
        settle_block();
    endtask

    task automatic test_extreme_heights();
        write_register(REG_GRID_WIDTH, 20'd3);
        write_register(REG_GRID_HEIGHT, 20'd3);
        write_register(REG_DROP_THRESHOLD, THR_MAX);
        write_register(REG_RISE_THRESHOLD, THR_MAX);
        // A single peak in a floor at full negative scale reaches both
        // thresholds exactly.
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                send_height((r == 1 && c == 1) ? HEIGHT_MAX : HEIGHT_MIN);
            end
        end
        settle_block();
    endtask

    task automatic test_odd_settings();
        logic [HEIGHT_W-1:0] ramp [6];
        ramp = '{20'h00000, 20'h00010, 20'h00020, 20'hFFFF0, 20'h0000F, 20'h00011};
        write_register(REG_GRID_WIDTH, '0);
        write_register(REG_GRID_HEIGHT, '0);
        send_height('1);
        send_height(20'h00010);
        settle_block();
        // Upper data bits beyond each register's width must be dropped.
        write_register(REG_GRID_WIDTH, 20'hFF802);
        write_register(REG_GRID_HEIGHT, 20'hF0002);
        write_register(REG_DROP_THRESHOLD, 20'd16);
        write_register(REG_RISE_THRESHOLD, 20'd16);
        foreach (ramp[i]) send_height(ramp[i]);
        settle_block();
        // An unmapped index must neither change a setting nor restart the grid.
        write_register(REG_UNMAPPED, 20'hABCDE);
        send_height(20'h00030);
        send_height(20'hFFFE0);
        settle_block();
    endtask

    task automatic test_tall_grid();
        write_register(REG_GRID_WIDTH, 20'd3);
        write_register(REG_GRID_HEIGHT, CFG_DATA_BITS'((1 << GH_BITS) - 1));
        write_register(REG_DROP_THRESHOLD, 20'd40);
        write_register(REG_RISE_THRESHOLD, 20'd40);
        terrain_base = int'($urandom_range(1000000)) - 500000;
        repeat (15) send_height(pick_height());
        settle_block();
    endtask

    task automatic test_wide_rows();
        // A single full-width row, so every sample after the first releases
        // a cell of the row itself.
        write_register(REG_GRID_WIDTH, CFG_DATA_BITS'(MAX_CELLS));
        write_register(REG_GRID_HEIGHT, 20'd1);
        write_register(REG_DROP_THRESHOLD, pick_threshold());
        write_register(REG_RISE_THRESHOLD, pick_threshold());
        terrain_base = int'($urandom_range(1000000)) - 500000;
        repeat (WIDE_SAMPLES) send_height(pick_height());
        settle_block();
        // A width above the line buffer size is clamped to it.
        write_register(REG_GRID_WIDTH, CFG_DATA_BITS'((1 << GW_BITS) - 1));
        write_register(REG_GRID_HEIGHT, 20'd1);
        repeat (WIDE_SAMPLES) send_height(pick_height());
        settle_block();
    endtask

    task automatic test_random_grids();
        int goal, phase, w, h, cells, pause_at, pick;
        goal  = samples_sent + RANDOM_SAMPLES;
        phase = 0;
        while (samples_sent < goal) begin
            steady = (phase == 2);
            terrain_base = int'($urandom_range(1000000)) - 500000;
            pick = $urandom_range(9);
            if (pick < 7)      w = $urandom_range(1, 8);
            else if (pick < 9) w = $urandom_range(9, 32);
            else               w = $urandom_range(33, 64);
            h = $urandom_range(1, 6);
            write_register(REG_GRID_WIDTH, CFG_DATA_BITS'(w));
            write_register(REG_GRID_HEIGHT, CFG_DATA_BITS'(h));
            write_register(REG_DROP_THRESHOLD, pick_threshold());
            write_register(REG_RISE_THRESHOLD, pick_threshold());
            if ($urandom_range(3) == 0)
                write_register(CFG_ADDR_BITS'($urandom_range(REG_RISE_THRESHOLD + 1,
                                                              REG_ADDR_LAST)),
                               CFG_DATA_BITS'($urandom));
            cells = w * h * (($urandom_range(3) == 0) ? 2 : 1);
            if ($urandom_range(4) == 0) cells = $urandom_range(1, cells);
            if (phase < 2 && cells > PHASE_CELLS) cells = PHASE_CELLS;
            // The steady phase runs on to the end of the random stream.
            if (phase == 2 || cells > goal - samples_sent) cells = goal - samples_sent;
            pause_at = (phase == 1 || (phase != 2 && $urandom_range(2) == 0)) ?
                       $urandom_range(0, cells - 1) : -1;
            for (int i = 0; i < cells; i++) begin
                if (i == pause_at) begin
                    // Pause mid-grid until the block has drained, then maybe
                    // retune a threshold or restart the grid.
                    settle_block();
                    pick = $urandom_range(3);
                    if (pick == 0)
                        write_register(REG_DROP_THRESHOLD, pick_threshold());
                    else if (pick == 1)
                        write_register(REG_RISE_THRESHOLD, pick_threshold());
                    else if (pick == 2)
                        write_register(REG_GRID_WIDTH, CFG_DATA_BITS'(w));
                end
                send_height(pick_height());
            end
            settle_block();
            phase++;
        end
        steady = 1'b0;
    endtask

    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 33);
    end

    always @(posedge aclk) begin : check_results
        result_t      got;
        cell_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[RESULT_BITS-1:0]);
            if (expected_cells.size() == 0) begin
                error_count++;
                if (report_count < REPORT_MAX) begin
                    report_count++;
                    $display("Unexpected result item: col %0d row %0d drop %0b rise %0b last %0b",
                             got.cell_column, got.cell_row, got.drop_flag, got.rise_flag,
                             m_tlast);
                end
            end else begin
                want = expected_cells.pop_front();
                results_checked++;
                if (got.cell_column !== want.column || got.cell_row !== want.row ||
                    got.drop_flag !== want.drop || got.rise_flag !== want.rise ||
                    m_tlast !== want.last) begin
                    error_count++;
                    if (report_count < REPORT_MAX) begin
                        report_count++;
                        $display("Mismatch: expected col %0d row %0d drop %0b rise %0b last %0b",
                                 want.column, want.row, want.drop, want.rise, want.last);
                        $display("          actual   col %0d row %0d drop %0b rise %0b last %0b",
                                 got.cell_column, got.cell_row, got.drop_flag,
                                 got.rise_flag, m_tlast);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_cells.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_extreme_heights();
        test_odd_settings();
        test_tall_grid();
        test_wide_rows();
        test_random_grids();
        settle_block();
        $display("Sent %0d height samples and checked %0d cell results across %0d register writes.",
                 samples_sent, results_checked, cfg_writes);
        $display("Grids ranged from single cells to %0d-cell rows, thresholds from zero to full scale.",
                 MAX_CELLS);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
